[rtl/color_ramp_interpolator_top_assert.svh]
// assertion macros for the colour ramp interpolator
// used by cri_ctrl and cri_datapath, which need clk and rst_n in scope
`ifndef COLOR_RAMP_INTERPOLATOR_TOP_ASSERT_SVH
`define COLOR_RAMP_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CRI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define CRI_ASSERT_ALWAYS(lbl, expr, msg) \
    `CRI_ASSERT(lbl, expr, msg)
`else
`define CRI_ASSERT(lbl, prop, msg)
`define CRI_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

[rtl/cri_pkg.sv]
// shared types and codes for the colour ramp interpolator
// no dependencies
`timescale 1ns / 1ps
package cri_pkg;

    localparam int VALUE_BITS   = 8;
    localparam int CMD_BITS     = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADVANCE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SEEK    = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_START_VALUE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_VALUE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    typedef struct packed {
        logic restart_load;
        logic seek_load;
        logic advance;
        logic div_step;
        logic commit_restart;
        logic commit_seek;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

[rtl/cri_if.sv]
// request and result channel interfaces of the colour ramp interpolator
// depends on cri_pkg
`timescale 1ns / 1ps
interface cri_req_if #(parameter int COUNT_BITS = 12);
    import cri_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   cmd;
    logic [COUNT_BITS-1:0] position;
    modport source (output valid, output cmd, output position, input ready);
    modport sink (input valid, input cmd, input position, output ready);
endinterface

interface cri_rsp_if #(parameter int COUNT_BITS = 12);
    import cri_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] fraction;
    modport source (output valid, output value, output fraction, input ready);
    modport sink (input valid, input value, input fraction, output ready);
endinterface

[rtl/cri_ctrl.sv]
// controller state machine of the colour ramp interpolator
// depends on cri_pkg and the assertion header
`timescale 1ns / 1ps
`include "color_ramp_interpolator_top_assert.svh"
module cri_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [cri_pkg::CMD_BITS-1:0] in_cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  cri_pkg::stat_t              stat,
    output cri_pkg::ctl_t               ctl
);
    import cri_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   op_seek_reg;
    logic   op_seek_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_seek_next = op_seek_reg;
        ctl          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_cmd)
                        CMD_RESTART:
                        begin
                            ctl.restart_load = 1'b1;
                            op_seek_next     = 1'b0;
                            state_next       = S_DIV;
                        end
                        CMD_SEEK:
                        begin
                            ctl.seek_load = 1'b1;
                            op_seek_next  = 1'b1;
                            state_next    = S_DIV;
                        end
                        CMD_ADVANCE:
                        begin
                            ctl.advance = 1'b1;
                            state_next  = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    ctl.commit_seek    = op_seek_reg;
                    ctl.commit_restart = !op_seek_reg;
                    state_next         = S_OUT;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_seek_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_seek_reg   <= op_seek_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CRI_ASSERT(a_long_op_enters_div, (in_valid && in_ready && (in_cmd == CMD_RESTART || in_cmd == CMD_SEEK)) |=> (state_reg == S_DIV), "restart or seek did not start division")
    `CRI_ASSERT(a_out_load_sets_valid, ctl.out_load |=> out_valid_reg, "result load did not raise valid")
    `CRI_ASSERT_ALWAYS(a_one_command, $onehot0(ctl), "more than one datapath command")

endmodule

[rtl/cri_datapath.sv]
// datapath of the colour ramp interpolator: config registers, ramp state,
// seek multiplier, bit-serial divider and result register; depends on cri_pkg
`timescale 1ns / 1ps
`include "color_ramp_interpolator_top_assert.svh"
module cri_datapath #(
    parameter int COUNT_BITS = 12,
    localparam int CFG_W = (COUNT_BITS > cri_pkg::VALUE_BITS) ? COUNT_BITS : cri_pkg::VALUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cri_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    input  logic [COUNT_BITS-1:0]            position,
    input  cri_pkg::ctl_t                    ctl,
    output cri_pkg::stat_t                   stat,
    output logic [cri_pkg::VALUE_BITS-1:0]   value,
    output logic [COUNT_BITS-1:0]            fraction
);
    import cri_pkg::*;

    localparam int PW    = 2 * COUNT_BITS + 1;
    localparam int QW    = VALUE_BITS + COUNT_BITS;
    localparam int CNT_W = $clog2(PW + 1);
    localparam logic [COUNT_BITS-1:0] STEPS_RST   = COUNT_BITS'(256);
    localparam logic [COUNT_BITS-1:0] DIVISOR_RST = COUNT_BITS'(255);

    logic [VALUE_BITS-1:0] start_reg, start_next;
    logic [VALUE_BITS-1:0] end_reg, end_next;
    logic [COUNT_BITS-1:0] steps_reg, steps_next;

    logic [VALUE_BITS-1:0] cur_reg, cur_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] held_reg, held_next;
    logic [COUNT_BITS-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic [PW-1:0]         dividend_reg, dividend_next;
    logic [COUNT_BITS-1:0] divrem_reg, divrem_next;
    logic [VALUE_BITS-1:0] vq_reg, vq_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [COUNT_BITS-1:0] fraction_reg, fraction_next;

    logic [VALUE_BITS-1:0]            span;
    logic [PW-1:0]                    prod;
    logic [QW-1:0]                    qprod;
    logic [COUNT_BITS:0]              shifted;
    logic [COUNT_BITS:0]              shift_diff;
    logic                             shift_ge;
    logic [COUNT_BITS:0]              asum;
    logic [COUNT_BITS:0]              asum_diff;
    logic                             carry;

    assign stat.div_done = (count_reg == '0);
    assign value         = value_reg;
    assign fraction      = fraction_reg;

    // configuration writes
    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        steps_next = steps_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_VALUE: start_next = cfg_data[VALUE_BITS-1:0];
                REG_END_VALUE:   end_next   = cfg_data[VALUE_BITS-1:0];
                REG_STEP_COUNT:  steps_next = cfg_data[COUNT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign span       = end_reg - start_reg;
    assign prod       = PW'(rem_reg) * PW'(position) + PW'(divisor_reg >> 1);
    assign qprod      = QW'(quot_reg) * QW'(position);
    assign shifted    = {divrem_reg, dividend_reg[PW-1]};
    assign shift_ge   = shifted >= {1'b0, divisor_reg};
    assign shift_diff = shifted - {1'b0, divisor_reg};
    assign asum       = {1'b0, acc_reg} + {1'b0, rem_reg};
    assign carry      = asum >= {1'b0, divisor_reg};
    assign asum_diff  = asum - {1'b0, divisor_reg};

    always_comb
    begin
        cur_next      = cur_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        acc_next      = acc_reg;
        held_next     = held_reg;
        divisor_next  = divisor_reg;
        count_next    = count_reg;
        dividend_next = dividend_reg;
        divrem_next   = divrem_reg;
        vq_next       = vq_reg;
        value_next    = value_reg;
        fraction_next = fraction_reg;

        if (ctl.restart_load)
        begin
            divisor_next  = (steps_reg < COUNT_BITS'(2)) ? COUNT_BITS'(1)
                                                          : steps_reg - COUNT_BITS'(1);
            held_next     = start_reg;
            dividend_next = {span, {(PW - VALUE_BITS){1'b0}}};
            divrem_next   = '0;
            count_next    = CNT_W'(VALUE_BITS);
        end

        if (ctl.seek_load)
        begin
            dividend_next = prod;
            vq_next       = qprod[VALUE_BITS-1:0];
            divrem_next   = '0;
            count_next    = CNT_W'(PW);
        end

        if (ctl.advance)
        begin
            cur_next = cur_reg + quot_reg + VALUE_BITS'(carry);
            acc_next = carry ? asum_diff[COUNT_BITS-1:0] : asum[COUNT_BITS-1:0];
        end

        // one quotient bit per cycle, restoring
        if (ctl.div_step)
        begin
            divrem_next   = shift_ge ? shift_diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            dividend_next = {dividend_reg[PW-2:0], shift_ge};
            count_next    = count_reg - CNT_W'(1);
        end

        if (ctl.commit_restart)
        begin
            quot_next = dividend_reg[VALUE_BITS-1:0];
            rem_next  = divrem_reg;
            acc_next  = divisor_reg >> 1;
            cur_next  = held_reg;
        end

        if (ctl.commit_seek)
        begin
            acc_next = divrem_reg;
            cur_next = vq_reg + dividend_reg[VALUE_BITS-1:0] + held_reg;
        end

        if (ctl.out_load)
        begin
            value_next    = cur_reg;
            fraction_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            end_reg     <= {VALUE_BITS{1'b1}};
            steps_reg   <= STEPS_RST;
            cur_reg     <= '0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            acc_reg     <= '0;
            held_reg    <= '0;
            divisor_reg <= DIVISOR_RST;
            count_reg   <= '0;
        end
        else
        begin
            start_reg   <= start_next;
            end_reg     <= end_next;
            steps_reg   <= steps_next;
            cur_reg     <= cur_next;
            quot_reg    <= quot_next;
            rem_reg     <= rem_next;
            acc_reg     <= acc_next;
            held_reg    <= held_next;
            divisor_reg <= divisor_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divrem_reg   <= divrem_next;
        vq_reg       <= vq_next;
        value_reg    <= value_next;
        fraction_reg <= fraction_next;
    end

    `CRI_ASSERT(a_acc_below_divisor, ctl.out_load |-> (acc_reg < divisor_reg), "accumulator not below divisor")
    `CRI_ASSERT(a_rem_below_divisor, ctl.out_load |-> (rem_reg < divisor_reg), "step remainder not below divisor")
    `CRI_ASSERT(a_div_load_busy, (ctl.restart_load || ctl.seek_load) |=> !stat.div_done, "division loaded with zero bits")

endmodule

[rtl/color_ramp_interpolator_top.sv]
// Colour ramp interpolator: linear ramp of one 8-bit component.
// req channel carries cmd (restart, advance, seek) and position; rsp channel
// returns value and fraction, one transfer for every accepted request.
// The config port writes start_value, end_value and step_count (index 0..2);
// writes take effect at the next restart.
// One request is handled at a time; the result sits in an output register,
// so a new request is taken while a result still waits on rsp.
// Path from request transfer to rsp valid:
//   advance or unused cmd: straight to the output state
//   restart: 8 divider steps, then the commit and the output state
//   seek: one quotient bit per cycle over the 2*COUNT_BITS+1 bit product
// Reset clears the ramp state to start 0, divisor 255, registers to their
// defaults, and empties the output register.
// When rsp stalls with a result waiting, the next finished result is held and
// req.ready stays low until the output register frees.
// Depends on cri_pkg, cri_if, cri_ctrl and cri_datapath.
`timescale 1ns / 1ps
module color_ramp_interpolator_top #(
    parameter int COUNT_BITS = 12,
    localparam int CFG_W = (COUNT_BITS > cri_pkg::VALUE_BITS) ? COUNT_BITS : cri_pkg::VALUE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cri_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    cri_req_if.sink                          req,
    cri_rsp_if.source                        rsp
);
    import cri_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    cri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_cmd    (req.cmd),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    cri_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .position  (req.position),
        .ctl       (ctl),
        .stat      (stat),
        .value     (rsp.value),
        .fraction  (rsp.fraction)
    );

endmodule

[tb/tb_color_ramp_interpolator_top.sv]
// self-checking testbench for color_ramp_interpolator_top: directed and random ramps
// predicts every result with its own ramp model and checks each rsp transfer in order
// depends on cri_pkg, cri_if and color_ramp_interpolator_top
`timescale 1ns / 1ps
module tb_color_ramp_interpolator_top;
    import cri_pkg::*;

    localparam int COUNT_BITS = 12;
    localparam int CFG_W = (COUNT_BITS > VALUE_BITS) ? COUNT_BITS : VALUE_BITS;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_POS = (1 << COUNT_BITS) - 2;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [COUNT_BITS-1:0] fraction;
    } ramp_point_t;

    class ramp_tracker;
        logic [VALUE_BITS-1:0] start_reg = '0;
        logic [VALUE_BITS-1:0] end_reg = 8'd255;
        logic [COUNT_BITS-1:0] count_reg = 12'd256;
        logic [VALUE_BITS-1:0] cur_value = '0;
        logic [VALUE_BITS-1:0] step_quot = '0;
        logic [COUNT_BITS-1:0] step_rem = '0;
        logic [COUNT_BITS-1:0] acc = '0;
        logic [VALUE_BITS-1:0] held_start = '0;
        logic [COUNT_BITS-1:0] divisor = 12'd255;
        ramp_point_t expected_points[$];
        int unsigned per_cmd[4] = '{0, 0, 0, 0};
        int unsigned checked = 0;
        int unsigned errors = 0;

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_START_VALUE: start_reg = data[VALUE_BITS-1:0];
                REG_END_VALUE:   end_reg = data[VALUE_BITS-1:0];
                REG_STEP_COUNT:  count_reg = data[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [CMD_BITS-1:0] cmd, logic [COUNT_BITS-1:0] where);
            logic [VALUE_BITS-1:0] span;
            longint unsigned prod;
            int unsigned acc_sum;
            logic [VALUE_BITS-1:0] v;
            ramp_point_t p;
            case (cmd)
                CMD_RESTART:
                begin
                    span = end_reg - start_reg;
                    divisor = (count_reg < 2) ? 12'd1 : count_reg - 12'd1;
                    held_start = start_reg;
                    step_quot = 8'(int'(span) / int'(divisor));
                    step_rem = 12'(int'(span) % int'(divisor));
                    acc = divisor >> 1;
                    cur_value = held_start;
                end
                CMD_ADVANCE:
                begin
                    cur_value = cur_value + step_quot;
                    acc_sum = int'(acc) + int'(step_rem);
                    if (acc_sum >= divisor)
                    begin
                        cur_value = cur_value + 8'd1;
                        acc_sum = acc_sum - divisor;
                    end
                    acc = 12'(acc_sum);
                end
                CMD_SEEK:
                begin
                    prod = longint'(step_rem) * longint'(where) + longint'(divisor >> 1);
                    v = 8'(int'(step_quot) * int'(where)) + 8'(prod / divisor);
                    acc = 12'(prod % divisor);
                    cur_value = v + held_start;
                end
                default: ;
            endcase
            p.value = cur_value;
            p.fraction = acc;
            expected_points.push_back(p);
            per_cmd[cmd]++;
        endfunction

        function void check_result(logic [VALUE_BITS-1:0] value, logic [COUNT_BITS-1:0] fraction);
            ramp_point_t p;
            if (expected_points.size() == 0)
            begin
                $error("result with nothing outstanding: value %0d fraction %0d", value, fraction);
                errors++;
                return;
            end
            p = expected_points.pop_front();
            checked++;
            if (value !== p.value)
            begin
                $error("value: expected %0d, actual %0d", p.value, value);
                errors++;
            end
            if (fraction !== p.fraction)
            begin
                $error("fraction: expected %0d, actual %0d", p.fraction, fraction);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    bit calm;
    int unsigned cycles;
    int unsigned phases;
    ramp_tracker ramp = new();

    cri_req_if #(.COUNT_BITS(COUNT_BITS)) req_ch ();
    cri_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_ch ();

    color_ramp_interpolator_top #(.COUNT_BITS(COUNT_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, ramp.expected_points.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // transfers on both channels, results checked before new requests are noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                ramp.check_result(rsp_ch.value, rsp_ch.fraction);
            if (req_ch.valid && req_ch.ready)
                ramp.note_request(req_ch.cmd, req_ch.position);
        end
    end

    // result side stalls
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [COUNT_BITS-1:0] where);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.position <= where;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (ramp.expected_points.size() != 0);
    endtask

    task automatic put_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        ramp.write_reg(idx, data);
    endtask

    task automatic program_ramp(logic [CFG_W-1:0] s, logic [CFG_W-1:0] e, logic [CFG_W-1:0] n);
        put_reg(REG_START_VALUE, s);
        put_reg(REG_END_VALUE, e);
        put_reg(REG_STEP_COUNT, n);
        cfg_we <= 1'b0;
        phases++;
    endtask

    function automatic logic [CFG_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_W'(255);
            2: return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
            default: return CFG_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        logic [CFG_W-1:0] n;
        logic [CMD_BITS-1:0] cmd;
        int sent;
        int phase_len;
        int pick;
        int top_pos;
        logic [COUNT_BITS-1:0] where;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_RESTART;
        req_ch.position = '0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ramp: advance, seek and unused cmd, before and after a first restart
        send_request(CMD_ADVANCE, 12'hFFF);
        send_request(CMD_ADVANCE, '0);
        send_request(CMD_SEEK, 12'd4094);
        send_request(CMD_UNUSED, 12'd17);
        send_request(CMD_RESTART, '0);
        send_request(CMD_ADVANCE, '0);
        send_request(CMD_ADVANCE, '0);
        send_request(CMD_SEEK, '0);
        send_request(CMD_SEEK, 12'd255);
        send_request(CMD_SEEK, 12'd4094);
        send_request(CMD_UNUSED, 12'd4094);
        drain_results();

        // falling ramp, registers only count from the next restart
        program_ramp(12'd255, 12'd0, 12'd4095);
        send_request(CMD_ADVANCE, '0);
        send_request(CMD_RESTART, '0);
        send_request(CMD_ADVANCE, '0);
        send_request(CMD_SEEK, 12'd4094);
        send_request(CMD_SEEK, 12'd1);
        drain_results();

        // shortest legal ramp, seek past the end
        program_ramp(12'd0, 12'd255, 12'd2);
        send_request(CMD_RESTART, '0);
        send_request(CMD_ADVANCE, '0);
        send_request(CMD_SEEK, 12'd1);
        send_request(CMD_SEEK, 12'd4094);
        drain_results();

        // step counts below two
        program_ramp(12'd10, 12'd200, 12'd0);
        send_request(CMD_RESTART, '0);
        send_request(CMD_ADVANCE, '0);
        drain_results();
        program_ramp(12'd10, 12'd200, 12'd1);
        send_request(CMD_RESTART, '0);
        send_request(CMD_ADVANCE, '0);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0: n = 12'd2;
                1: n = 12'd4095;
                2: n = CFG_W'($urandom_range(2, 16));
                3: n = CFG_W'($urandom_range(0, 1));
                4, 5: n = CFG_W'($urandom_range(2, 300));
                default: n = CFG_W'($urandom_range(2, 4095));
            endcase
            program_ramp(pick_level(), pick_level(), n);
            top_pos = (n < 2) ? MAX_POS : int'(n) - 1;
            phase_len = $urandom_range(20, 80);
            if ($urandom_range(0, 9) != 0)
            begin
                send_request(CMD_RESTART, COUNT_BITS'($urandom_range(0, MAX_POS)));
                sent++;
            end
            for (int i = 0; i < phase_len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    cmd = CMD_RESTART;
                else if (pick < 62)
                    cmd = CMD_ADVANCE;
                else if (pick < 95)
                    cmd = CMD_SEEK;
                else
                    cmd = CMD_UNUSED;
                if ($urandom_range(0, 1) == 0)
                    where = COUNT_BITS'($urandom_range(0, top_pos));
                else
                    where = COUNT_BITS'($urandom_range(0, MAX_POS));
                send_request(cmd, where);
                sent++;
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        $display("covered %0d restarts, %0d advances, %0d seeks, %0d unused commands",
                 ramp.per_cmd[CMD_RESTART], ramp.per_cmd[CMD_ADVANCE],
                 ramp.per_cmd[CMD_SEEK], ramp.per_cmd[CMD_UNUSED]);
        $display("%0d results checked over %0d register settings in %0d cycles",
                 ramp.checked, phases, cycles);
        if (ramp.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
